/* sv/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and codes for the first-fit range allocator: extent entry
// layout, request opcodes, response status codes and default sizes.
// ----------------------------------------------------------------------------
package ffa_pkg;

   // width of slot numbers, counts and capacity
   localparam int WORD_W = 16;

   // default depth of the extent table
   localparam int DEF_MAX_EXTENTS = 64;

   // capacity after reset
   localparam logic [WORD_W-1:0] CAP_RESET = 16'd1024;

   // request opcodes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // response status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NO_SPACE   = 2'd1;
   localparam logic [1:0] ST_TABLE_FULL = 2'd2;

   // one free extent: covers slots end_pos-size .. end_pos-1
   typedef struct packed {
      logic [WORD_W-1:0] end_pos;
      logic [WORD_W-1:0] size;
   } extent_type;

endpackage

/* sv/ffa_if.sv */
// ----------------------------------------------------------------------------
// ffa_if
// Valid/ready channels of the allocator: request, response and the
// capacity register write port.
// ----------------------------------------------------------------------------
interface ffa_req_if import ffa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [WORD_W-1:0] count;
   logic [WORD_W-1:0] offset;

   modport source (output valid, output cmd, output count, output offset, input ready);
   modport sink   (input valid, input cmd, input count, input offset, output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] alloc_offset;
   logic [1:0]        status;

   modport source (output valid, output alloc_offset, output status, input ready);
   modport sink   (input valid, input alloc_offset, input status, output ready);
endinterface

interface ffa_csr_if import ffa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] capacity;

   modport source (output valid, output capacity, input ready);
   modport sink   (input valid, input capacity, output ready);
endinterface

/* sv/ffa_mem.sv */
// ----------------------------------------------------------------------------
// ffa_mem
// Extent table storage: one write port, one read port, read data
// registered (old data on a same-address collision).
// ----------------------------------------------------------------------------
module ffa_mem import ffa_pkg::*; #(
   parameter int DEPTH = DEF_MAX_EXTENTS
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  extent_type                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output extent_type                 rd_data
);

   extent_type ext_mem [DEPTH];
   extent_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ext_mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= ext_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/ffa_ctrl.sv */
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer of the allocator: streams the extent table through the read
// port for first-fit and neighbor searches, shifts entries one per cycle
// on erase and insert, and holds the capacity and response registers.
// ----------------------------------------------------------------------------
module ffa_ctrl import ffa_pkg::*; #(
   parameter int MAX_EXTENTS = DEF_MAX_EXTENTS
) (
   input  logic                             clock,
   input  logic                             reset,
   ffa_req_if.sink                          req_chan,
   ffa_rsp_if.source                        rsp_chan,
   ffa_csr_if.sink                          csr_chan,
   output logic                             mem_we,
   output logic [$clog2(MAX_EXTENTS)-1:0]   mem_waddr,
   output extent_type                       mem_wdata,
   output logic [$clog2(MAX_EXTENTS)-1:0]   mem_raddr,
   input  extent_type                       mem_rdata
);

   localparam int IW = $clog2(MAX_EXTENTS);
   localparam int CW = $clog2(MAX_EXTENTS + 1);

   // sequencer states
   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_FDEC  = 3'd3;
   localparam logic [2:0] S_SHIFT = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   // search kinds
   localparam logic [1:0] SCAN_ALLOC  = 2'd0;
   localparam logic [1:0] SCAN_FREE   = 2'd1;
   localparam logic [1:0] SCAN_INSERT = 2'd2;

   logic [2:0]        state_ff, state_in;
   logic [WORD_W-1:0] cap_ff, cap_in;
   logic [CW-1:0]     ext_cnt_ff, ext_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   logic [WORD_W-1:0] rq_count_ff, rq_count_in;
   logic [WORD_W-1:0] rq_offset_ff, rq_offset_in;
   logic [WORD_W-1:0] new_end_ff, new_end_in;
   logic [WORD_W-1:0] new_size_ff, new_size_in;
   logic [WORD_W-1:0] res_offset_ff, res_offset_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic [1:0]        mode_ff, mode_in;
   logic [CW-1:0]     iss_ff, iss_in;
   logic [CW-1:0]     chk_ff, chk_in;
   logic              vld_ff, vld_in;
   extent_type        prev_ff, prev_in;
   logic              has_prev_ff, has_prev_in;
   logic [CW-1:0]     up_ff, up_in;
   extent_type        up_ent_ff, up_ent_in;
   logic              up_vld_ff, up_vld_in;
   logic [CW-1:0]     sh_src_ff, sh_src_in;
   logic [CW-1:0]     sh_last_ff, sh_last_in;
   logic              sh_up_ff, sh_up_in;
   logic              sh_done_ff, sh_done_in;
   logic              then_ins_ff, then_ins_in;
   logic              fin_wr_ff, fin_wr_in;
   logic [CW-1:0]     fin_idx_ff, fin_idx_in;
   logic [CW-1:0]     ins_start_ff, ins_start_in;

   logic [WORD_W:0]   req_end;
   logic              iss_ok;
   logic              hit;
   logic              merge_prev;
   logic              merge_next;
   logic [WORD_W-1:0] sum_next;
   logic [WORD_W-1:0] sum_both;
   logic [CW-1:0]     wr_idx;
   extent_type        rd;

   assign rd      = mem_rdata;
   assign req_end = {1'b0, req_chan.offset} + {1'b0, req_chan.count};
   assign iss_ok  = iss_ff < ext_cnt_ff;

   // per-search match on the entry now on the read port
   always_comb begin
      case (mode_ff)
         SCAN_ALLOC:  hit = rd.size >= rq_count_ff;
         SCAN_FREE:   hit = rd.end_pos > rq_offset_ff;
         default:     hit = rd.end_pos >= new_end_ff;
      endcase
   end

   // merge decision for a free
   assign merge_prev = has_prev_ff && (prev_ff.end_pos == rq_offset_ff);
   assign merge_next = up_vld_ff && ((up_ent_ff.end_pos - up_ent_ff.size) == new_end_ff);
   assign sum_next   = up_ent_ff.size + rq_count_ff;
   assign sum_both   = sum_next + prev_ff.size;

   // shift write target
   assign wr_idx = sh_up_ff ? chk_ff + CW'(1) : chk_ff - CW'(1);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      ext_cnt_in    = ext_cnt_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_chan.ready;
      rsp_offset_in = rsp_offset_ff;
      rsp_status_in = rsp_status_ff;
      rq_count_in   = rq_count_ff;
      rq_offset_in  = rq_offset_ff;
      new_end_in    = new_end_ff;
      new_size_in   = new_size_ff;
      res_offset_in = res_offset_ff;
      res_status_in = res_status_ff;
      mode_in       = mode_ff;
      iss_in        = iss_ff;
      chk_in        = chk_ff;
      vld_in        = 1'b0;
      prev_in       = prev_ff;
      has_prev_in   = has_prev_ff;
      up_in         = up_ff;
      up_ent_in     = up_ent_ff;
      up_vld_in     = up_vld_ff;
      sh_src_in     = sh_src_ff;
      sh_last_in    = sh_last_ff;
      sh_up_in      = sh_up_ff;
      sh_done_in    = sh_done_ff;
      then_ins_in   = then_ins_ff;
      fin_wr_in     = fin_wr_ff;
      fin_idx_in    = fin_idx_ff;
      ins_start_in  = ins_start_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_raddr     = '0;

      unique case (state_ff)
         // rebuild the table as one extent over the whole pool
         S_INIT: begin
            mem_we     = 1'b1;
            mem_wdata  = '{end_pos: cap_ff, size: cap_ff};
            ext_cnt_in = (cap_ff != '0) ? CW'(1) : '0;
            state_in   = S_IDLE;
         end

         // take a request and pick the first search
         S_IDLE: begin
            if (req_chan.valid) begin
               rq_count_in   = req_chan.count;
               rq_offset_in  = req_chan.offset;
               new_end_in    = req_end[WORD_W-1:0];
               new_size_in   = req_chan.count;
               res_offset_in = '0;
               res_status_in = ST_OK;
               iss_in        = '0;
               has_prev_in   = 1'b0;
               then_ins_in   = 1'b0;
               fin_wr_in     = 1'b0;
               if (req_chan.cmd == CMD_ALLOC) begin
                  mode_in = SCAN_ALLOC;
                  if (req_chan.count == '0) begin
                     res_status_in = ST_NO_SPACE;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else begin
                  mode_in = SCAN_FREE;
                  if (req_chan.count == '0 || req_end[WORD_W]) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
            end
         end

         // stream entries one per cycle, test each as it returns
         S_SCAN: begin
            mem_raddr = iss_ff[IW-1:0];
            vld_in    = iss_ok;
            chk_in    = iss_ff;
            iss_in    = iss_ff + CW'(iss_ok);
            if (vld_ff && hit) begin
               vld_in = 1'b0;
               case (mode_ff)
                  SCAN_ALLOC: begin
                     res_offset_in = rd.end_pos - rd.size;
                     if (rd.size == rq_count_ff) begin
                        // exact fit: drop the extent
                        ext_cnt_in = ext_cnt_ff - CW'(1);
                        sh_src_in  = chk_ff + CW'(1);
                        sh_last_in = ext_cnt_ff - CW'(1);
                        sh_up_in   = 1'b0;
                        sh_done_in = 1'b0;
                        state_in   = (chk_ff + CW'(1) < ext_cnt_ff) ? S_SHIFT : S_DONE;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = chk_ff[IW-1:0];
                        mem_wdata = '{end_pos: rd.end_pos, size: rd.size - rq_count_ff};
                        state_in  = S_DONE;
                     end
                  end
                  SCAN_FREE: begin
                     up_in     = chk_ff;
                     up_ent_in = rd;
                     up_vld_in = 1'b1;
                     state_in  = S_FDEC;
                  end
                  default: begin
                     if (rd.end_pos == new_end_ff) begin
                        // same end already present: new extent dropped
                        state_in = S_DONE;
                     end else begin
                        // open a gap at the hit position
                        ext_cnt_in = ext_cnt_ff + CW'(1);
                        sh_src_in  = ext_cnt_ff - CW'(1);
                        sh_last_in = chk_ff;
                        sh_up_in   = 1'b1;
                        sh_done_in = 1'b0;
                        fin_wr_in  = 1'b1;
                        fin_idx_in = chk_ff;
                        state_in   = S_SHIFT;
                     end
                  end
               endcase
            end else if (vld_ff) begin
               prev_in     = rd;
               has_prev_in = 1'b1;
            end else if (!iss_ok) begin
               // ran off the end of the table
               case (mode_ff)
                  SCAN_ALLOC: begin
                     res_status_in = ST_NO_SPACE;
                     state_in      = S_DONE;
                  end
                  SCAN_FREE: begin
                     up_in     = ext_cnt_ff;
                     up_vld_in = 1'b0;
                     state_in  = S_FDEC;
                  end
                  default: begin
                     mem_we     = 1'b1;
                     mem_waddr  = ext_cnt_ff[IW-1:0];
                     mem_wdata  = '{end_pos: new_end_ff, size: new_size_ff};
                     ext_cnt_in = ext_cnt_ff + CW'(1);
                     state_in   = S_DONE;
                  end
               endcase
            end
         end

         // free: merge with neighbors, prepare an insert, or reject when the table is full
         S_FDEC: begin
            sh_up_in   = 1'b0;
            sh_done_in = 1'b0;
            if (merge_next) begin
               if (merge_prev) begin
                  // merged extent lands in the previous slot, old next slot erased
                  mem_we     = 1'b1;
                  mem_waddr  = IW'(up_ff - CW'(1));
                  mem_wdata  = '{end_pos: up_ent_ff.end_pos, size: sum_both};
                  ext_cnt_in = ext_cnt_ff - CW'(1);
                  sh_src_in  = up_ff + CW'(1);
                  sh_last_in = ext_cnt_ff - CW'(1);
                  state_in   = (up_ff + CW'(1) < ext_cnt_ff) ? S_SHIFT : S_DONE;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = up_ff[IW-1:0];
                  mem_wdata = '{end_pos: up_ent_ff.end_pos, size: sum_next};
                  state_in  = S_DONE;
               end
            end else if (!merge_prev && ext_cnt_ff >= CW'(MAX_EXTENTS)) begin
               res_status_in = ST_TABLE_FULL;
               state_in      = S_DONE;
            end else if (merge_prev) begin
               // erase the previous extent, then insert the grown one
               new_size_in  = rq_count_ff + prev_ff.size;
               ext_cnt_in   = ext_cnt_ff - CW'(1);
               ins_start_in = up_ff - CW'(1);
               sh_src_in    = up_ff;
               sh_last_in   = ext_cnt_ff - CW'(1);
               mode_in      = SCAN_INSERT;
               if (up_vld_ff) begin
                  then_ins_in = 1'b1;
                  state_in    = S_SHIFT;
               end else begin
                  iss_in   = up_ff - CW'(1);
                  state_in = S_SCAN;
               end
            end else begin
               mode_in  = SCAN_INSERT;
               iss_in   = up_ff;
               state_in = S_SCAN;
            end
         end

         // move entries one place, read one and write one per cycle
         S_SHIFT: begin
            if (!sh_done_ff) begin
               mem_raddr = sh_src_ff[IW-1:0];
               vld_in    = 1'b1;
               chk_in    = sh_src_ff;
               if (sh_src_ff == sh_last_ff) begin
                  sh_done_in = 1'b1;
               end else begin
                  sh_src_in = sh_up_ff ? sh_src_ff - CW'(1) : sh_src_ff + CW'(1);
               end
            end
            if (vld_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wr_idx[IW-1:0];
               mem_wdata = rd;
               if (sh_done_ff && chk_ff == sh_last_ff) begin
                  if (then_ins_ff) begin
                     then_ins_in = 1'b0;
                     iss_in      = ins_start_ff;
                     state_in    = S_SCAN;
                  end else if (fin_wr_ff) begin
                     state_in = S_FIN;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end
         end

         // place the new extent into the opened gap
         S_FIN: begin
            mem_we    = 1'b1;
            mem_waddr = fin_idx_ff[IW-1:0];
            mem_wdata = '{end_pos: new_end_ff, size: new_size_ff};
            fin_wr_in = 1'b0;
            state_in  = S_DONE;
         end

         // hand the result to the response register
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_offset_in = res_offset_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // capacity write refills the table
      if (csr_chan.valid) begin
         cap_in   = csr_chan.capacity;
         state_in = S_INIT;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cap_ff       <= CAP_RESET;
         ext_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         ext_cnt_ff   <= ext_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         vld_ff       <= vld_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rsp_offset_ff <= rsp_offset_in;
      rsp_status_ff <= rsp_status_in;
      rq_count_ff   <= rq_count_in;
      rq_offset_ff  <= rq_offset_in;
      new_end_ff    <= new_end_in;
      new_size_ff   <= new_size_in;
      res_offset_ff <= res_offset_in;
      res_status_ff <= res_status_in;
      mode_ff       <= mode_in;
      iss_ff        <= iss_in;
      chk_ff        <= chk_in;
      prev_ff       <= prev_in;
      has_prev_ff   <= has_prev_in;
      up_ff         <= up_in;
      up_ent_ff     <= up_ent_in;
      up_vld_ff     <= up_vld_in;
      sh_src_ff     <= sh_src_in;
      sh_last_ff    <= sh_last_in;
      sh_up_ff      <= sh_up_in;
      sh_done_ff    <= sh_done_in;
      then_ins_ff   <= then_ins_in;
      fin_wr_ff     <= fin_wr_in;
      fin_idx_ff    <= fin_idx_in;
      ins_start_ff  <= ins_start_in;
   end

   // channel outputs; a capacity write takes priority over a new request
   assign req_chan.ready       = (state_ff == S_IDLE) && !csr_chan.valid;
   assign csr_chan.ready       = 1'b1;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.alloc_offset = rsp_offset_ff;
   assign rsp_chan.status      = rsp_status_ff;

endmodule

/* sv/first_fit_range_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_range_allocator
// Slot pool allocator over a sorted table of free extents in one memory.
// ----------------------------------------------------------------------------
// Request time: grows with the entries that the search passes, with the
//   entries moved when the table shifts, and with a merge or an insert.
// Throughput: one request in flight; the table's one read port and one write
//   port, one entry per cycle, set the rate. The response register frees the core.
// Reset and capacity writes: entry 0 is rebuilt, request ready held low.
// ----------------------------------------------------------------------------
module first_fit_range_allocator import ffa_pkg::*; #(
   parameter int MAX_EXTENTS = DEF_MAX_EXTENTS
) (
   input  logic       clock,
   input  logic       reset,
   ffa_req_if.sink    req_chan,
   ffa_rsp_if.source  rsp_chan,
   ffa_csr_if.sink    csr_chan
);

   localparam int IW = $clog2(MAX_EXTENTS);

   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   extent_type    mem_wdata;
   logic [IW-1:0] mem_raddr;
   extent_type    mem_rdata;

   // sequencer
   ffa_ctrl #(
      .MAX_EXTENTS (MAX_EXTENTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_chan  (csr_chan),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // extent table
   ffa_mem #(
      .DEPTH (MAX_EXTENTS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // core is busy right after taking a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request taken while previous request still in work");

   // table rebuild blocks requests
   a_busy_after_csr: assert property (@(posedge clock) disable iff (reset)
      csr_chan.valid && csr_chan.ready |=> !req_chan.ready)
      else $error("request taken during table rebuild");

   // a failed or rejected request never reports an offset
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status != ST_OK |-> rsp_chan.alloc_offset == '0)
      else $error("nonzero offset on failed response");

endmodule
